// ===== design/tccs_pkg.sv =====
// Shared types, codes and defaults of the text console cursor and scroll block.
package tccs_pkg;

   localparam int TCCS_COLUMNS = 80;
   localparam int TCCS_ROWS    = 25;

   // Character bytes that the put operation reacts to.
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_READ   = 2'd1,
      OP_REPORT = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_FILL = 2'd0,
      ST_IDLE = 2'd1,
      ST_READ = 2'd2
   } state_type;

endpackage

// ===== design/tccs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module tccs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/text_console_cursor_scroll_top.sv =====
// Top level of the text console: character grid, cursor, scroll and screen clear.
//
//  channel | direction | tvalid/tready        | tdata / tuser contents
//  --------+-----------+---------------------+------------------------------------------
//  req     | in        | req_tvalid/tready   | tuser: opcode; tdata: char, row, col
//  rsp     | out       | rsp_tvalid/tready   | tdata: cursor, linear, char, dirty, scroll
//
// A put, a report and a read of a cell outside the grid are answered from the result
// register alone; a read of a cell inside the grid also passes through the registered
// read port of the grid RAM and the read state. A put that scrolls is answered at once,
// then the new bottom line is filled with spaces; a clear is answered at once, then the
// whole grid is zeroed. No transfer is accepted during these fills. After reset the same
// clearing pass runs.
// A transfer is accepted only while the result register is empty or being drained.
// The grid is kept as a ring of rows: a scroll moves the top-row pointer, not the data.
module text_console_cursor_scroll_top
   import tccs_pkg::*;
#(
   parameter int COLUMNS = TCCS_COLUMNS,
   parameter int ROWS    = TCCS_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tuser: [1:0] opcode
   input  logic [1:0]  req_tuser,
   // tdata: [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: [4:0] cursor_row, [11:5] cursor_col, [22:12] cursor_linear,
   //        [30:23] read_char, [31] dirty_flag, [32] scrolled, [39:33] zero
   output logic [39:0] rsp_tdata
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int LW    = $clog2(CELLS + 1);

   // Fields of the incoming transfer.
   op_type      req_opcode;
   logic [7:0]  req_char;
   logic [6:0]  req_row_ext;
   logic [8:0]  req_col_ext;

   assign req_opcode  = op_type'(req_tuser);
   assign req_char    = req_tdata[7:0];
   assign req_row_ext = 7'(req_tdata[12:8]);
   assign req_col_ext = 9'(req_tdata[19:13]);

   // Control and cursor state.
   state_type    state_ff, state_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic          dirty_ff, dirty_in;
   logic [RW-1:0] top_ff, top_in;
   logic [AW-1:0] sweep_addr_ff, sweep_addr_in;
   logic [LW-1:0] sweep_left_ff, sweep_left_in;
   logic [7:0]    fill_byte_ff, fill_byte_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    rsp_row_ff, rsp_row_in;
   logic [6:0]    rsp_col_ff, rsp_col_in;
   logic [10:0]   rsp_linear_ff, rsp_linear_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_dirty_ff, rsp_dirty_in;
   logic          rsp_scrolled_ff, rsp_scrolled_in;

   // Grid RAM port signals.
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   logic          accept;

   // Maps a row on screen and a column to a RAM address through the ring of rows.
   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [RW-1:0] top,
                                                input logic [CW-1:0] col);
      logic [RW:0]   sum;
      logic [RW-1:0] phys;
      begin
         sum = {1'b0, row} + {1'b0, top};
         if (sum >= (RW+1)'(ROWS)) begin
            phys = RW'(sum - (RW+1)'(ROWS));
         end else begin
            phys = RW'(sum);
         end
         cell_addr = AW'(phys) * AW'(COLUMNS) + AW'(col);
      end
   endfunction

   // Cursor movement of a put, with the wrap at the right edge and the scroll check.
   logic [CW:0]   put_col;
   logic [RW:0]   put_row;
   logic [CW:0]   tab_col;
   logic          printable;
   logic          put_scroll;
   logic [RW-1:0] put_row_final;
   logic [CW-1:0] put_col_final;
   logic [RW-1:0] top_next;

   always_comb begin
      printable = (req_char >= CH_SPACE) && (req_char <= CH_TILDE);
      tab_col   = {1'b0, cur_col_ff} + (CW+1)'(4);
      put_col   = {1'b0, cur_col_ff};
      put_row   = {1'b0, cur_row_ff};
      if (printable) begin
         put_col = {1'b0, cur_col_ff} + (CW+1)'(1);
      end else if (req_char == CH_BS) begin
         if (cur_col_ff != '0) begin
            put_col = {1'b0, cur_col_ff} - (CW+1)'(1);
         end
      end else if (req_char == CH_TAB) begin
         put_col = {tab_col[CW:2], 2'b00};
      end else if (req_char == CH_LF) begin
         put_row = {1'b0, cur_row_ff} + (RW+1)'(1);
         put_col = '0;
      end else if (req_char == CH_CR) begin
         put_col = '0;
      end

      // Running off the right edge wraps to the start of the next row.
      if (put_col >= (CW+1)'(COLUMNS)) begin
         put_col = '0;
         put_row = put_row + (RW+1)'(1);
      end

      // Running off the bottom scrolls by one line and keeps the cursor on the last row.
      put_scroll = put_row >= (RW+1)'(ROWS);
      if (put_scroll) begin
         put_row_final = RW'(ROWS - 1);
      end else begin
         put_row_final = RW'(put_row);
      end
      put_col_final = CW'(put_col);

      if (top_ff == RW'(ROWS - 1)) begin
         top_next = '0;
      end else begin
         top_next = top_ff + RW'(1);
      end
   end

   // Read request decode.
   logic          read_in_range;
   logic [AW-1:0] read_addr;

   assign read_in_range = (req_row_ext < 7'(ROWS)) && (req_col_ext < 9'(COLUMNS));
   assign read_addr     = cell_addr(RW'(req_row_ext), top_ff, CW'(req_col_ext));

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      logic [AW-1:0] lin_full;
      state_in        = state_ff;
      cur_row_in      = cur_row_ff;
      cur_col_in      = cur_col_ff;
      dirty_in        = dirty_ff;
      top_in          = top_ff;
      sweep_addr_in   = sweep_addr_ff;
      sweep_left_in   = sweep_left_ff;
      fill_byte_in    = fill_byte_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_linear_in   = rsp_linear_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_dirty_in    = rsp_dirty_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = cell_addr(cur_row_ff, top_ff, cur_col_ff);
      ram_wr_data     = req_char;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = read_addr;
      lin_full        = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_FILL: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = sweep_addr_ff;
            ram_wr_data   = fill_byte_ff;
            sweep_addr_in = sweep_addr_ff + AW'(1);
            sweep_left_in = sweep_left_ff - LW'(1);
            if (sweep_left_ff == LW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            // The grid RAM returns the cell in the cycle after the request.
            rsp_valid_in = 1'b1;
            rsp_char_in  = ram_rd_data;
            state_in     = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_char_in     = CH_NUL;
               rsp_scrolled_in = 1'b0;
               rsp_valid_in    = 1'b1;
               unique case (req_opcode)
                  OP_PUT: begin
                     ram_wr_en       = printable;
                     cur_row_in      = put_row_final;
                     cur_col_in      = put_col_final;
                     dirty_in        = 1'b1;
                     rsp_scrolled_in = put_scroll;
                     if (put_scroll) begin
                        // The old top row becomes the new bottom line.
                        top_in        = top_next;
                        sweep_addr_in = AW'(top_ff) * AW'(COLUMNS);
                        sweep_left_in = LW'(COLUMNS);
                        fill_byte_in  = CH_SPACE;
                        state_in      = ST_FILL;
                     end
                  end
                  OP_READ: begin
                     if (read_in_range) begin
                        ram_rd_en    = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end
                  end
                  OP_REPORT: begin
                     dirty_in = 1'b0;
                  end
                  OP_CLEAR: begin
                     cur_row_in    = '0;
                     cur_col_in    = '0;
                     dirty_in      = 1'b1;
                     top_in        = '0;
                     sweep_addr_in = '0;
                     sweep_left_in = LW'(CELLS);
                     fill_byte_in  = CH_NUL;
                     state_in      = ST_FILL;
                  end
                  default: begin
                  end
               endcase
               lin_full      = AW'(cur_row_in) * AW'(COLUMNS) + AW'(cur_col_in);
               rsp_row_in    = 5'(cur_row_in);
               rsp_col_in    = 7'(cur_col_in);
               rsp_linear_in = 11'(lin_full);
               // A report shows the mark as it stood before it was cleared.
               rsp_dirty_in  = (req_opcode == OP_REPORT) ? dirty_ff : dirty_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         dirty_ff      <= 1'b1;
         top_ff        <= '0;
         sweep_addr_ff <= '0;
         sweep_left_ff <= LW'(CELLS);
         fill_byte_ff  <= CH_NUL;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         dirty_ff      <= dirty_in;
         top_ff        <= top_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_left_ff <= sweep_left_in;
         fill_byte_ff  <= fill_byte_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_linear_ff   <= rsp_linear_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_dirty_ff    <= rsp_dirty_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   tccs_ram #(
      .WIDTH(8),
      .DEPTH(CELLS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_scrolled_ff, rsp_dirty_ff, rsp_char_ff,
                        rsp_linear_ff, rsp_col_ff, rsp_row_ff};

endmodule

// ===== design/tccs_checker.sv =====
// Port-level assertions for the text console top level, with the bind that attaches them.
module tccs_checker
   import tccs_pkg::*;
#(
   parameter int COLUMNS = TCCS_COLUMNS,
   parameter int ROWS    = TCCS_ROWS
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // Reset empties the result register and starts the clearing pass.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block not quiet after reset");

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A clear transfer is answered at once with the cursor home and the grid dirty.
   a_clear_home: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_CLEAR) |=>
         rsp_tvalid && (rsp_tdata[22:0] == 23'd0) && rsp_tdata[31] && !rsp_tdata[32])
      else $error("clear result wrong");

   // A report is answered at once, with no character and no scroll.
   a_report_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_REPORT) |=>
         rsp_tvalid && (rsp_tdata[30:23] == 8'd0) && !rsp_tdata[32])
      else $error("report result wrong");

   // The linear position agrees with row and column when neither is truncated.
   a_linear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ROWS > 32) || (COLUMNS > 128) ||
         (rsp_tdata[22:12] == 11'(32'(rsp_tdata[4:0]) * COLUMNS + 32'(rsp_tdata[11:5]))))
      else $error("linear cursor position inconsistent");

endmodule

bind text_console_cursor_scroll_top tccs_checker #(
   .COLUMNS(COLUMNS),
   .ROWS(ROWS)
) u_tccs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/console_reply_checker.sv =====
// Watches both console channels, predicts every reply and compares it with the block.
`timescale 1ns / 1ps

module console_reply_checker
   import tccs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          mismatches,
   output int          awaited,
   output int          checked,
   output int          scrolls
);

   localparam int CELLS = TCCS_ROWS * TCCS_COLUMNS;

   // Reply fields from the most significant down, so that the struct lines up with tdata.
   typedef struct packed {
      logic        scrolled;
      logic        dirty;
      logic [7:0]  glyph;
      logic [10:0] linear;
      logic [6:0]  col;
      logic [4:0]  row;
   } console_reply_t;

   logic [7:0]     screen [CELLS];
   int             cur_row;
   int             cur_col;
   logic           dirty_mark;
   console_reply_t pending_replies[$];
   console_reply_t want;
   console_reply_t got;

   initial begin
      mismatches = 0;
      awaited    = 0;
      checked    = 0;
      scrolls    = 0;
   end

   task automatic home_and_blank();
      for (int i = 0; i < CELLS; i++) screen[i] = CH_NUL;
      cur_row    = 0;
      cur_col    = 0;
      dirty_mark = 1'b1;
   endtask

   task automatic apply_request(input op_type op, input logic [7:0] code,
                                input logic [4:0] rrow, input logic [6:0] rcol,
                                output console_reply_t reply);
      logic       rolled;
      logic [7:0] glyph;
      logic       flag;
      rolled = 1'b0;
      glyph  = CH_NUL;
      case (op)
         OP_PUT: begin
            if (code >= CH_SPACE && code <= CH_TILDE) begin
               screen[cur_row * TCCS_COLUMNS + cur_col] = code;
               cur_col++;
            end else if (code == CH_BS) begin
               if (cur_col != 0) cur_col--;
            end else if (code == CH_TAB) begin
               cur_col = (cur_col + 4) & ~3;
            end else if (code == CH_LF) begin
               cur_row++;
               cur_col = 0;
            end else if (code == CH_CR) begin
               cur_col = 0;
            end
            if (cur_col >= TCCS_COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
            // Falling off the bottom moves every line up and opens a blank last line.
            if (cur_row >= TCCS_ROWS) begin
               for (int i = 0; i < CELLS - TCCS_COLUMNS; i++)
                  screen[i] = screen[i + TCCS_COLUMNS];
               for (int i = CELLS - TCCS_COLUMNS; i < CELLS; i++) screen[i] = CH_SPACE;
               cur_row = TCCS_ROWS - 1;
               rolled  = 1'b1;
            end
            dirty_mark = 1'b1;
            flag       = dirty_mark;
         end
         OP_READ: begin
            if (rrow < TCCS_ROWS && rcol < TCCS_COLUMNS)
               glyph = screen[rrow * TCCS_COLUMNS + rcol];
            flag = dirty_mark;
         end
         OP_REPORT: begin
            // The report returns the mark as it stood, then clears it.
            flag       = dirty_mark;
            dirty_mark = 1'b0;
         end
         default: begin
            home_and_blank();
            flag = dirty_mark;
         end
      endcase
      reply.row      = 5'(cur_row);
      reply.col      = 7'(cur_col);
      reply.linear   = 11'(cur_row * TCCS_COLUMNS + cur_col);
      reply.glyph    = glyph;
      reply.dirty    = flag;
      reply.scrolled = rolled;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         home_and_blank();
         pending_replies.delete();
         awaited = 0;
      end else begin
         // A reply never belongs to a request taken at the same edge, so retire first.
         if (rsp_tvalid && rsp_tready) begin
            got = console_reply_t'(rsp_tdata[32:0]);
            if (pending_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: reply with none awaited: row %0d col %0d lin %0d char %h",
                           $realtime, got.row, got.col, got.linear, got.glyph);
            end else begin
               want = pending_replies.pop_front();
               checked++;
               if (want.scrolled) scrolls++;
               if (got.row != want.row || got.col != want.col || got.linear != want.linear ||
                   got.glyph != want.glyph || got.dirty != want.dirty ||
                   got.scrolled != want.scrolled) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: reply %0d expected row %0d col %0d lin %0d char %h dirty %b scr %b",
                              $realtime, checked, want.row, want.col, want.linear, want.glyph,
                              want.dirty, want.scrolled);
                     $display("%0t: reply %0d actual   row %0d col %0d lin %0d char %h dirty %b scr %b",
                              $realtime, checked, got.row, got.col, got.linear, got.glyph,
                              got.dirty, got.scrolled);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(op_type'(req_tuser), req_tdata[7:0], req_tdata[12:8],
                          req_tdata[19:13], want);
            pending_replies.push_back(want);
         end
         awaited = pending_replies.size();
      end
   end

endmodule

// ===== tb/text_console_cursor_scroll_top_tb.sv =====
// Stimulus, flow control and verdict for the text console cursor and scroll block.
`timescale 1ns / 1ps

module text_console_cursor_scroll_top_tb;
   import tccs_pkg::*;

   // The grid size sets the longest stall of the block: a clear, and the clearing pass
   // after reset, keep the request side closed while every cell is written.
   localparam int CELLS       = TCCS_ROWS * TCCS_COLUMNS;
   localparam int ITEM_TARGET = 1550;
   localparam int MAX_GAP     = 8;
   localparam int MAX_STALL   = 6;
   // The slowest correct run would have every request wait out a full clear, the longest
   // sender gap and the longest receiver stall. An episode may overshoot the target by a
   // hundred or so transfers. The limit takes that three times over.
   localparam int LIMIT =
      3 * (CELLS + (ITEM_TARGET + 150) * (CELLS + MAX_GAP + MAX_STALL + 4));

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = OP_PUT;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   int mismatches;
   int awaited;
   int checked;
   int scrolls;

   int cycles = 0;
   int burst_left = 0;
   int items_sent = 0;
   int puts = 0;
   int reads = 0;
   int reports = 0;
   int clears = 0;

   // The receiver switches between stretches of different stall behavior.
   int stall_mode = 0;
   int mode_left = 0;
   int hold = 0;

   text_console_cursor_scroll_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   console_reply_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .awaited    (awaited),
      .checked    (checked),
      .scrolls    (scrolls)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Timeout after %0d cycles with %0d replies outstanding.", cycles, awaited);
         $display("text_console_cursor_scroll_top regression: fail");
         $finish;
      end
   end

   // Receiver. Mode 0 always takes a transfer, mode 1 drops ready at random, and mode 2
   // holds ready low for short runs now and then.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(40, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 9) < 7);
         default: begin
            if (hold != 0) begin
               rsp_tready <= 1'b0;
               hold--;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 3) == 0) hold = $urandom_range(1, MAX_STALL);
            end
         end
      endcase
   end

   // Presents one request at a falling edge and returns at the falling edge after the
   // transfer. Between bursts the valid line drops for a random gap; a zero gap joins
   // two bursts, so valid is never lowered and raised in the same step.
   task automatic send(input op_type op, input logic [7:0] code,
                       input logic [4:0] row, input logic [6:0] col);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, MAX_GAP);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 30);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0000, col, row, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      items_sent++;
      case (op)
         OP_PUT:    puts++;
         OP_READ:   reads++;
         OP_REPORT: reports++;
         default:   clears++;
      endcase
   endtask

   // The cell fields mean nothing to a put, so they carry random bits there.
   task automatic put_char(input logic [7:0] code);
      send(OP_PUT, code, 5'($urandom), 7'($urandom));
   endtask

   task automatic read_cell(input logic [4:0] row, input logic [6:0] col);
      send(OP_READ, 8'($urandom), row, col);
   endtask

   task automatic put_text(input int count);
      for (int i = 0; i < count; i++) put_char(8'($urandom_range(CH_SPACE, CH_TILDE)));
   endtask

   initial begin
      int pick;
      int count;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The screen starts blank and dirty; reports clear the mark.
      read_cell(5'd0, 7'd0);
      send(OP_REPORT, CH_NUL, 5'd0, 7'd0);
      send(OP_REPORT, CH_NUL, 5'd0, 7'd0);
      read_cell(5'd24, 7'd79);
      // Both ends of the printable range, then one in the middle.
      put_char(CH_SPACE);
      put_char(CH_TILDE);
      put_char(8'h41);
      read_cell(5'd0, 7'd1);
      // Carriage return to column 0, where a backspace must leave the cursor alone.
      put_char(CH_CR);
      put_char(CH_BS);
      put_char(CH_TAB);
      put_char(CH_TAB);
      put_char(CH_BS);
      // Bytes that store nothing and move nothing, but still mark the screen dirty.
      send(OP_REPORT, CH_NUL, 5'd0, 7'd0);
      put_char(8'h7F);
      put_char(8'hFF);
      put_char(CH_NUL);
      put_char(8'h1B);
      // Reads outside the grid return zero.
      read_cell(5'd25, 7'd0);
      read_cell(5'd0, 7'd80);
      read_cell(5'd31, 7'd127);
      put_char(CH_LF);
      send(OP_CLEAR, 8'hFF, 5'd31, 7'd127);
      read_cell(5'd0, 7'd0);

      // Random part, built from episodes. Most of it is text with line endings, so the
      // cursor keeps reaching the bottom row and the screen scrolls often.
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            put_text($urandom_range(0, 14));
            put_char(($urandom_range(0, 4) == 0) ? CH_CR : CH_LF);
         end else if (pick < 55) begin
            // Long lines wrap past the right edge.
            put_text($urandom_range(60, 100));
         end else if (pick < 65) begin
            count = $urandom_range(1, 6);
            repeat (count) begin
               case ($urandom_range(0, 3))
                  0: put_char(CH_BS);
                  1: put_char(CH_TAB);
                  2: put_char(CH_CR);
                  default: put_char(CH_LF);
               endcase
            end
         end else if (pick < 80) begin
            count = $urandom_range(1, 4);
            repeat (count) begin
               if ($urandom_range(0, 99) < 85)
                  read_cell(5'($urandom_range(0, TCCS_ROWS - 1)),
                            7'($urandom_range(0, TCCS_COLUMNS - 1)));
               else
                  read_cell(5'($urandom), 7'($urandom));
            end
         end else if (pick < 88) begin
            count = $urandom_range(1, 2);
            repeat (count) send(OP_REPORT, 8'($urandom), 5'($urandom), 7'($urandom));
         end else if (pick < 89) begin
            send(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
         end else begin
            // Noise: every field fully random, clears included.
            count = $urandom_range(1, 5);
            repeat (count)
               send(op_type'($urandom_range(0, 3)), 8'($urandom), 5'($urandom), 7'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      // Drain the replies, then give a trailing clear time to finish so that any stray
      // reply would still be seen.
      while (awaited != 0) @(negedge clock);
      repeat (CELLS + 16) @(negedge clock);

      $display("Sent %0d transfers: %0d puts, %0d cell reads, %0d reports, %0d clears.",
               items_sent, puts, reads, reports, clears);
      $display("Checked %0d replies, %0d of which scrolled the screen; %0d mismatches.",
               checked, scrolls, mismatches);
      if (mismatches == 0) begin
         $display("text_console_cursor_scroll_top regression: pass");
      end else begin
         $display("text_console_cursor_scroll_top regression: fail");
      end
      $finish;
   end

endmodule
